// File: sv/mcsc_pkg.sv
// Shared types, constants and the symbol reduction table for the multiset
// cover substring counter. No dependencies.
package mcsc_pkg;

    localparam int WINDOW_DEPTH = 4096;
    localparam int MAX_TEXT     = 65536;
    localparam int ALPHABET     = 256;

    localparam int SYM_W   = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
    localparam int ADDR_W  = $clog2(WINDOW_DEPTH);
    localparam int CNT_W   = $clog2(((MAX_TEXT > WINDOW_DEPTH) ? MAX_TEXT : WINDOW_DEPTH) + 1);
    localparam int MISS_W  = 13;
    localparam int BAL_W   = ((MISS_W > ADDR_W) ? MISS_W : ADDR_W) + 1;
    localparam int TOTAL_W = 32;

    localparam logic [MISS_W-1:0] MISSING_MAX = {MISS_W{1'b1}};

    localparam logic [1:0] FUNC_CLEAR   = 2'd0;
    localparam logic [1:0] FUNC_PATTERN = 2'd1;
    localparam logic [1:0] FUNC_TEXT    = 2'd2;

    typedef logic [SYM_W-1:0]        t_sym;
    typedef logic [ADDR_W-1:0]       t_addr;
    typedef logic [CNT_W-1:0]        t_cnt;
    typedef logic [MISS_W-1:0]       t_miss;
    typedef logic signed [BAL_W-1:0] t_bal;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] symbol;
    } t_in_item;

    typedef struct packed {
        logic [TOTAL_W-1:0] running_total;
        logic               window_overflow;
        logic               text_too_long;
    } t_out_item;

    // Request to the balance table: clear, one read and one write per cycle.
    typedef struct packed {
        logic clear;
        logic rd_en;
        t_sym rd_addr;
        logic wr_en;
        t_sym wr_addr;
        t_bal wr_data;
    } t_bal_req;

    typedef t_sym t_sym_tab [256];

    // Byte to symbol index, reduced modulo the alphabet size.
    function automatic t_sym_tab build_sym_tab();
        t_sym_tab tab;
        for (int i = 0; i < 256; i++) begin
            tab[i] = t_sym'(i % ALPHABET);
        end
        return tab;
    endfunction

    localparam t_sym_tab SYM_MOD = build_sym_tab();

endpackage

// File: sv/mcsc_bal_table.sv
// Per-symbol balance table: memory with one registered read port, one write
// port and a valid bit per entry so that a clear empties the table at once. Uses mcsc_pkg.
module mcsc_bal_table import mcsc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_bal_req i_req,
    output t_bal     o_rd_data
);

    t_bal                r_mem [ALPHABET];
    logic [ALPHABET-1:0] r_valid;
    t_bal                r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            // an entry not written since the last clear reads as zero
            r_rd_data <= r_valid[i_req.rd_addr] ? r_mem[i_req.rd_addr] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_req.clear) begin
            r_valid <= '0;
        end else if (i_req.wr_en) begin
            r_valid[i_req.wr_addr] <= 1'b1;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: sv/mcsc_text_ram.sv
// Window symbol buffer: circular store of recent text symbols, one write and
// one registered read per cycle. Uses mcsc_pkg.
module mcsc_text_ram import mcsc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_wr_en,
    input  t_addr i_wr_addr,
    input  t_sym  i_wr_data,
    input  logic  i_rd_en,
    input  t_addr i_rd_addr,
    output t_sym  o_rd_data
);

    t_sym r_mem [WINDOW_DEPTH];
    t_sym r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: sv/multiset_cover_substring_counter.sv
// Multiset cover substring counter, top level. Uses mcsc_pkg, mcsc_bal_table, mcsc_text_ram.
// A text item passes the balance update, the check and the result step, plus a text read,
// balance read and balance update per window start advance; past the length limit, only the result step.
// A pattern item takes a balance read and update, a clear item none. No new item is taken until
// the block is back in idle; a held result keeps the block in its result step and stalls input.
// Reset (synchronous, active low) empties the job and drops any pending result; ready at once.
module multiset_cover_substring_counter import mcsc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAT_UPD,
        S_DROP_BAL,
        S_DROP_UPD,
        S_INSERT,
        S_TEXT_UPD,
        S_CHECK,
        S_RESULT
    } t_state;

    t_state    r_state,     n_state;
    t_sym      r_sym,       n_sym;
    t_sym      r_bal_addr,  n_bal_addr;
    t_miss     r_missing,   n_missing;
    t_cnt      r_start,     n_start;
    t_cnt      r_end,       n_end;
    t_addr     r_start_idx, n_start_idx;
    t_addr     r_end_idx,   n_end_idx;
    logic [TOTAL_W-1:0] r_total, n_total;
    logic [1:0] r_flags,    n_flags;
    logic      r_ovf_drop,  n_ovf_drop;
    logic      r_add,       n_add;
    logic      r_out_valid, n_out_valid;
    t_out_item r_out_item,  n_out_item;

    t_bal_req  bal_req;
    t_bal      bal_old;
    t_bal      bal_new;
    logic      alu_dec;
    logic      txt_wr_en;
    t_addr     txt_wr_addr;
    t_sym      txt_wr_data;
    logic      txt_rd_en;
    t_sym      txt_rd_data;

    logic      in_acc;
    t_sym      sym_in;
    t_cnt      span;
    logic [TOTAL_W:0]   sum_wide;
    logic [TOTAL_W-1:0] total_sat;

    mcsc_bal_table u_bal (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (bal_req),
        .o_rd_data (bal_old)
    );

    mcsc_text_ram u_text (
        .i_clk     (i_clk),
        .i_wr_en   (txt_wr_en),
        .i_wr_addr (txt_wr_addr),
        .i_wr_data (txt_wr_data),
        .i_rd_en   (txt_rd_en),
        .i_rd_addr (r_start_idx),
        .o_rd_data (txt_rd_data)
    );

    // Only the idle state takes an item; everything else is one sequence.
    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign sym_in     = SYM_MOD[i_in_item.symbol];
    assign span       = r_end - r_start;

    // Shared balance unit: text insertion takes one away, every other update adds one.
    assign alu_dec = (r_state == S_TEXT_UPD);
    assign bal_new = alu_dec ? (bal_old - t_bal'(1)) : (bal_old + t_bal'(1));

    // Saturating add of the window start: covering substrings ending at this symbol.
    assign sum_wide  = {1'b0, r_total} + (TOTAL_W + 1)'(r_start);
    assign total_sat = sum_wide[TOTAL_W] ? {TOTAL_W{1'b1}} : sum_wide[TOTAL_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_sym       = r_sym;
        n_bal_addr  = r_bal_addr;
        n_missing   = r_missing;
        n_start     = r_start;
        n_end       = r_end;
        n_start_idx = r_start_idx;
        n_end_idx   = r_end_idx;
        n_total     = r_total;
        n_flags     = r_flags;
        n_ovf_drop  = r_ovf_drop;
        n_add       = r_add;
        // drop the held result once the far side takes it
        n_out_valid = r_out_valid && i_out_stall;
        n_out_item  = r_out_item;

        bal_req     = '0;
        txt_wr_en   = 1'b0;
        txt_wr_addr = r_end_idx;
        txt_wr_data = r_sym;
        txt_rd_en   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_sym = sym_in;
                    case (i_in_item.func)
                        FUNC_CLEAR: begin
                            // start a new job: every counter back to zero at once
                            bal_req.clear = 1'b1;
                            n_missing     = '0;
                            n_start       = '0;
                            n_end         = '0;
                            n_start_idx   = '0;
                            n_end_idx     = '0;
                            n_total       = '0;
                            n_flags       = '0;
                        end
                        FUNC_PATTERN: begin
                            // patterns count only before any text and while no error
                            if (r_end == '0 && r_flags == '0 && r_missing < MISSING_MAX) begin
                                bal_req.rd_en   = 1'b1;
                                bal_req.rd_addr = sym_in;
                                n_bal_addr      = sym_in;
                                n_state         = S_PAT_UPD;
                            end
                        end
                        FUNC_TEXT: begin
                            if (r_end >= CNT_W'(MAX_TEXT)) begin
                                // text limit passed: hold the total, report only
                                n_flags[1] = 1'b1;
                                n_add      = 1'b0;
                                n_state    = S_RESULT;
                            end else if (span >= CNT_W'(WINDOW_DEPTH)) begin
                                // buffer full: give back the oldest symbol first
                                n_flags[0] = 1'b1;
                                n_ovf_drop = 1'b1;
                                n_add      = 1'b1;
                                txt_rd_en  = 1'b1;
                                n_state    = S_DROP_BAL;
                            end else begin
                                // store the symbol and fetch its balance right away
                                txt_wr_en       = 1'b1;
                                txt_wr_data     = sym_in;
                                bal_req.rd_en   = 1'b1;
                                bal_req.rd_addr = sym_in;
                                n_bal_addr      = sym_in;
                                n_add           = 1'b1;
                                n_state         = S_TEXT_UPD;
                            end
                        end
                        default: begin
                            // unused code: no effect, no result
                        end
                    endcase
                end
            end
            S_PAT_UPD: begin
                bal_req.wr_en   = 1'b1;
                bal_req.wr_addr = r_bal_addr;
                bal_req.wr_data = bal_new;
                if (bal_new > 0) begin
                    n_missing = r_missing + t_miss'(1);
                end
                n_state = S_IDLE;
            end
            S_DROP_BAL: begin
                // oldest window symbol is out of the buffer: fetch its balance
                bal_req.rd_en   = 1'b1;
                bal_req.rd_addr = txt_rd_data;
                n_bal_addr      = txt_rd_data;
                n_state         = S_DROP_UPD;
            end
            S_DROP_UPD: begin
                bal_req.wr_en   = 1'b1;
                bal_req.wr_addr = r_bal_addr;
                bal_req.wr_data = bal_new;
                if (bal_new > 0) begin
                    n_missing = r_missing + t_miss'(1);
                end
                n_start     = r_start + t_cnt'(1);
                n_start_idx = (r_start_idx == t_addr'(WINDOW_DEPTH - 1)) ?
                              '0 : r_start_idx + t_addr'(1);
                n_ovf_drop  = 1'b0;
                n_state     = r_ovf_drop ? S_INSERT : S_CHECK;
            end
            S_INSERT: begin
                txt_wr_en       = 1'b1;
                bal_req.rd_en   = 1'b1;
                bal_req.rd_addr = r_sym;
                n_bal_addr      = r_sym;
                n_state         = S_TEXT_UPD;
            end
            S_TEXT_UPD: begin
                bal_req.wr_en   = 1'b1;
                bal_req.wr_addr = r_bal_addr;
                bal_req.wr_data = bal_new;
                if (bal_old > 0) begin
                    n_missing = r_missing - t_miss'(1);
                end
                n_end     = r_end + t_cnt'(1);
                n_end_idx = (r_end_idx == t_addr'(WINDOW_DEPTH - 1)) ?
                            '0 : r_end_idx + t_addr'(1);
                n_state   = S_CHECK;
            end
            S_CHECK: begin
                // shrink while the window still covers the multiset
                if (r_missing == '0 && r_start < r_end) begin
                    txt_rd_en = 1'b1;
                    n_state   = S_DROP_BAL;
                end else begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                // hold here until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_total                    = r_add ? total_sat : r_total;
                    n_out_item.running_total   = r_add ? total_sat : r_total;
                    n_out_item.window_overflow = r_flags[0];
                    n_out_item.text_too_long   = r_flags[1];
                    n_out_valid                = 1'b1;
                    n_state                    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_missing   <= '0;
            r_start     <= '0;
            r_end       <= '0;
            r_start_idx <= '0;
            r_end_idx   <= '0;
            r_total     <= '0;
            r_flags     <= '0;
            r_ovf_drop  <= 1'b0;
            r_add       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_missing   <= n_missing;
            r_start     <= n_start;
            r_end       <= n_end;
            r_start_idx <= n_start_idx;
            r_end_idx   <= n_end_idx;
            r_total     <= n_total;
            r_flags     <= n_flags;
            r_ovf_drop  <= n_ovf_drop;
            r_add       <= n_add;
            r_out_valid <= n_out_valid;
        end
        r_sym      <= n_sym;
        r_bal_addr <= n_bal_addr;
        r_out_item <= n_out_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef SYNTHESIS
    a_window_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_start <= r_end) && (span <= CNT_W'(WINDOW_DEPTH)))
        else $error("window bounds out of order or span beyond buffer depth");

    a_missing_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TEXT_UPD && bal_old > 0) |-> (r_missing != '0))
        else $error("missing count would wrap below zero");

    a_clear_empties_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_item.func == FUNC_CLEAR) |=>
        (r_total == '0 && r_start == '0 && r_end == '0 && r_flags == '0))
        else $error("clear item did not empty the job");

    a_result_from_sequence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_RESULT))
        else $error("result raised outside the result step");
`endif

endmodule

// File: tb/sv/tb.sv
// Self-checking bench for multiset_cover_substring_counter: drives clear, pattern and
// text items, predicts every running total and flag, and checks each result in order.
// Depends on mcsc_pkg and the RTL of the block.
module tb;
    import mcsc_pkg::*;

    localparam int CYCLE_LIMIT   = 4000000;
    localparam int RANDOM_ITEMS  = 840;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 64;

    // Function code with no meaning: the block must ignore it.
    localparam logic [1:0] FUNC_SPARE = 2'd3;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_stall;
    t_out_item out_item;

    // Expected totals and flags, oldest first.
    t_out_item expected_totals [$];
    t_out_item want;
    int        errors;

    // Idle control shared between the tests and the two traffic processes.
    bit send_idle;
    bit recv_idle;
    bit hold_req;

    // Predictor copy of the job state.
    int          sym_balance [ALPHABET];
    logic [7:0]  window_syms [WINDOW_DEPTH];
    int unsigned miss_cnt;
    int unsigned win_start;
    int unsigned win_end;
    logic [31:0] run_total;
    logic        ovf_flag;
    logic        long_flag;

    multiset_cover_substring_counter u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Empty the table and the window; used at reset and on a clear item.
    function automatic void start_job();
        for (int i = 0; i < ALPHABET; i++) begin
            sym_balance[i] = 0;
        end
        miss_cnt  = 0;
        win_start = 0;
        win_end   = 0;
        run_total = '0;
        ovf_flag  = 1'b0;
        long_flag = 1'b0;
    endfunction

    // Drop the oldest symbol from the window and give its count back.
    function automatic void release_oldest();
        int s;
        s = int'(window_syms[win_start % WINDOW_DEPTH]) % ALPHABET;
        sym_balance[s]++;
        if (sym_balance[s] > 0) begin
            miss_cnt++;
        end
        win_start++;
    endfunction

    // Advance the predicted state by one accepted item; queue a result for text.
    function automatic void predict_counter(input t_in_item item);
        int          s;
        logic [32:0] sum;
        t_out_item   res;
        s = int'(item.symbol) % ALPHABET;
        case (item.func)
            FUNC_CLEAR: begin
                start_job();
            end
            FUNC_PATTERN: begin
                // Patterns count only before the first text symbol and while no
                // error is flagged, and only up to the missing counter's range.
                if (win_end == 0 && !ovf_flag && !long_flag &&
                    miss_cnt < int'(MISSING_MAX)) begin
                    sym_balance[s]++;
                    if (sym_balance[s] > 0) begin
                        miss_cnt++;
                    end
                end
            end
            FUNC_TEXT: begin
                if (win_end >= MAX_TEXT) begin
                    // Past the length limit: hold the total, flag it.
                    long_flag = 1'b1;
                end else begin
                    // Full window: drop the oldest symbol to make room.
                    if (win_end - win_start >= WINDOW_DEPTH) begin
                        ovf_flag = 1'b1;
                        release_oldest();
                    end
                    window_syms[win_end % WINDOW_DEPTH] = item.symbol;
                    if (sym_balance[s] > 0) begin
                        miss_cnt--;
                    end
                    sym_balance[s]--;
                    win_end++;
                    // Shrink while the window still covers the multiset.
                    while (miss_cnt == 0 && win_start < win_end) begin
                        release_oldest();
                    end
                    sum = {1'b0, run_total} + 33'(win_start);
                    run_total = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                end
                res.running_total   = run_total;
                res.window_overflow = ovf_flag;
                res.text_too_long   = long_flag;
                expected_totals.insert(expected_totals.size(), res);
            end
            default: begin
                // Unused code: no effect, no result.
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Traffic
    // ------------------------------------------------------------------

    // Mostly zero, sometimes short, rarely a long stretch.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Offer one item, after a random gap when send_idle is set, hold it until accepted, then predict it.
    task automatic send_item(input logic [1:0] func, input logic [7:0] symbol);
        t_in_item item;
        int       gap;
        item.func   = func;
        item.symbol = symbol;
        gap = send_idle ? pick_gap() : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        do @(posedge clk); while (in_stall);
        predict_counter(item);
    endtask

    // Stop offering and wait until every expected result has come back.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_totals.size() != 0);
    endtask

    // Receiver stall: random bursts, or one long hold when a test asks for it.
    initial begin
        int stall_left;
        stall_left = 0;
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
            end else if (stall_left == 0 && recv_idle && $urandom_range(0, 3) == 0) begin
                stall_left = pick_gap();
            end
            if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Compare each accepted result with the oldest expectation, field by field.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (expected_totals.size() == 0) begin
                errors++;
                $display("%0t unexpected result: total %0d overflow %0b too_long %0b",
                         $time, out_item.running_total, out_item.window_overflow,
                         out_item.text_too_long);
            end else begin
                want = expected_totals.pop_front();
                if (out_item.running_total !== want.running_total) begin
                    errors++;
                    $display("%0t running_total expected %0d actual %0d",
                             $time, want.running_total, out_item.running_total);
                end
                if (out_item.window_overflow !== want.window_overflow) begin
                    errors++;
                    $display("%0t window_overflow expected %0b actual %0b",
                             $time, want.window_overflow, out_item.window_overflow);
                end
                if (out_item.text_too_long !== want.text_too_long) begin
                    errors++;
                    $display("%0t text_too_long expected %0b actual %0b",
                             $time, want.text_too_long, out_item.text_too_long);
                end
            end
        end
    end

    // Watchdog: a correct run ends far below this count.
    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("multiset_cover_substring_counter regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // No pattern: every substring counts, so the totals are 1, 3, 6.
    // An unused code in between must give no result.
    task automatic test_empty_multiset();
        send_item(FUNC_CLEAR, 8'h00);
        send_item(FUNC_TEXT, 8'h00);
        send_item(FUNC_TEXT, 8'hFF);
        send_item(FUNC_SPARE, 8'hAA);
        send_item(FUNC_TEXT, 8'h80);
    endtask

    // Repeated required symbol, symbol extremes, and a pattern after text
    // that must be ignored.
    task automatic test_multiset_cover();
        send_item(FUNC_CLEAR, 8'hFF);
        send_item(FUNC_PATTERN, 8'h00);
        send_item(FUNC_PATTERN, 8'h00);
        send_item(FUNC_PATTERN, 8'hFF);
        send_item(FUNC_TEXT, 8'hFF);
        send_item(FUNC_TEXT, 8'h00);
        send_item(FUNC_TEXT, 8'h12);
        send_item(FUNC_TEXT, 8'h00);
        send_item(FUNC_TEXT, 8'hFF);
        send_item(FUNC_PATTERN, 8'h12);
        send_item(FUNC_TEXT, 8'h00);
        send_item(FUNC_TEXT, 8'h12);
        send_item(FUNC_SPARE, 8'h55);
        send_item(FUNC_TEXT, 8'hFF);
    endtask

    // Hold the receiver off for a long stretch while text keeps coming, so
    // the block backs up and stalls its input; then pause until drained.
    task automatic test_backpressure();
        send_idle = 1'b0;
        send_item(FUNC_CLEAR, 8'h00);
        send_item(FUNC_PATTERN, 8'h5A);
        send_item(FUNC_PATTERN, 8'hA5);
        hold_req = 1'b1;
        for (int i = 0; i < 80; i++) begin
            case ($urandom_range(0, 2))
                0:       send_item(FUNC_TEXT, 8'h5A);
                1:       send_item(FUNC_TEXT, 8'hA5);
                default: send_item(FUNC_TEXT, 8'($urandom_range(0, 255)));
            endcase
        end
        wait_for_results();
        send_idle = 1'b1;
    endtask

    // Random jobs: a clear, a few required symbols from a small pool, then
    // text mostly drawn from the same pool so covers happen often. Mix in
    // off-pool symbols, late patterns and unused codes as noise.
    task automatic test_random_jobs();
        logic [7:0] pool [4];
        int         n_pool;
        int         sent;
        int         r;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            for (int i = 0; i < 4; i++) begin
                pool[i] = 8'($urandom_range(0, 255));
            end
            n_pool    = $urandom_range(1, 4);
            send_idle = ($urandom_range(0, 3) != 0);
            recv_idle = ($urandom_range(0, 3) != 0);
            send_item(FUNC_CLEAR, pool[0]);
            sent++;
            repeat ($urandom_range(0, 5)) begin
                send_item(FUNC_PATTERN, pool[$urandom_range(0, n_pool - 1)]);
                sent++;
            end
            repeat ($urandom_range(4, 40)) begin
                r = $urandom_range(0, 99);
                if (r < 85) begin
                    send_item(FUNC_TEXT, pool[$urandom_range(0, n_pool - 1)]);
                end else if (r < 90) begin
                    send_item(FUNC_TEXT, 8'($urandom_range(0, 255)));
                end else if (r < 95) begin
                    send_item(FUNC_PATTERN, pool[$urandom_range(0, n_pool - 1)]);
                end else begin
                    send_item(FUNC_SPARE, 8'($urandom_range(0, 255)));
                end
                sent++;
            end
            if ($urandom_range(0, 5) == 0) begin
                wait_for_results();
            end
        end
        send_idle = 1'b1;
        recv_idle = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        errors    = 0;
        send_idle = 1'b1;
        recv_idle = 1'b1;
        hold_req  = 1'b0;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_item  <= '0;
        start_job();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_multiset();
        test_multiset_cover();
        test_backpressure();
        test_random_jobs();

        // Drain, then let any stray result show up before judging.
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0) begin
            $display("multiset_cover_substring_counter regression: pass");
        end else begin
            $display("multiset_cover_substring_counter regression: fail");
        end
        $finish;
    end

endmodule
